[design/irot_pkg.sv]
`default_nettype none

package irot_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;

   localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_BITS  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int ADDR_BITS = ROW_BITS + COL_BITS;
   localparam int DEPTH     = 1 << ADDR_BITS;

   localparam int CHAN_BITS = 16;
   localparam int PIX_BITS  = 3 * CHAN_BITS;
   localparam int SIZE_BITS = 9;

   // Width used for position compares, wide enough for any counter + 1 and any size.
   localparam int EXT_BITS = ((COL_BITS > ROW_BITS ? COL_BITS : ROW_BITS) > SIZE_BITS ?
                              (COL_BITS > ROW_BITS ? COL_BITS : ROW_BITS) : SIZE_BITS) + 1;

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROTATE_RIGHT = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic                 write_en;
      logic                 read_en;
      logic [ADDR_BITS-1:0] addr;
      logic                 last;
   } mem_cmd_type;

   // A size of zero counts as one, a size above the maximum as the maximum.
   function automatic logic [EXT_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] value,
                                                      input int max_size);
      logic [EXT_BITS-1:0] result;
      result = EXT_BITS'(value);
      if (value == '0) begin
         result = EXT_BITS'(1);
      end else if (32'(value) > max_size) begin
         result = EXT_BITS'(max_size);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[design/irot_ram.sv]
`default_nettype none

module irot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic                     read_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         write_data,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem[addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

[design/irot_addr_gen.sv]
`default_nettype none

module irot_addr_gen (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic                             operation,
   input  wire logic                             restart,
   input  wire logic [irot_pkg::EXT_BITS-1:0]    eff_width,
   input  wire logic [irot_pkg::EXT_BITS-1:0]    eff_height,
   input  wire logic                             rotate_right,
   output irot_pkg::mem_cmd_type                 cmd,
   output logic                                  frame_full
);

   localparam int CB = irot_pkg::COL_BITS;
   localparam int RB = irot_pkg::ROW_BITS;
   localparam int EB = irot_pkg::EXT_BITS;

   logic [CB-1:0] load_col_ff, load_col_in;
   logic [RB-1:0] load_row_ff, load_row_in;
   // Readout rows walk source columns and readout columns walk source rows.
   logic [CB-1:0] emit_row_ff, emit_row_in;
   logic [RB-1:0] emit_col_ff, emit_col_in;
   logic          frame_full_ff, frame_full_in;

   logic [EB-1:0] load_col_next, load_row_next, emit_row_next, emit_col_next;
   logic [RB-1:0] src_row;
   logic [CB-1:0] src_col;
   logic          emit_last;

   always_comb begin
      load_col_next = EB'(load_col_ff) + EB'(1);
      load_row_next = EB'(load_row_ff) + EB'(1);
      emit_row_next = EB'(emit_row_ff) + EB'(1);
      emit_col_next = EB'(emit_col_ff) + EB'(1);
      emit_last     = (emit_row_next >= eff_width) && (emit_col_next >= eff_height);
      if (rotate_right) begin
         src_row = RB'(eff_height - EB'(1) - EB'(emit_col_ff));
         src_col = emit_row_ff;
      end else begin
         src_row = emit_col_ff;
         src_col = CB'(eff_width - EB'(1) - EB'(emit_row_ff));
      end
   end

   always_comb begin
      load_col_in   = load_col_ff;
      load_row_in   = load_row_ff;
      emit_row_in   = emit_row_ff;
      emit_col_in   = emit_col_ff;
      frame_full_in = frame_full_ff;
      cmd           = '0;

      if (restart) begin
         load_col_in   = '0;
         load_row_in   = '0;
         emit_row_in   = '0;
         emit_col_in   = '0;
         frame_full_in = 1'b0;
      end else if (accept && operation == irot_pkg::OP_LOAD && !frame_full_ff) begin
         cmd.write_en = 1'b1;
         cmd.addr     = {load_row_ff, load_col_ff};
         if (load_col_next >= eff_width) begin
            load_col_in = '0;
            if (load_row_next >= eff_height) begin
               load_row_in   = '0;
               frame_full_in = 1'b1;
               emit_row_in   = '0;
               emit_col_in   = '0;
            end else begin
               load_row_in = RB'(load_row_next);
            end
         end else begin
            load_col_in = CB'(load_col_next);
         end
      end else if (accept && operation == irot_pkg::OP_READ && frame_full_ff) begin
         cmd.read_en = 1'b1;
         cmd.addr    = {src_row, src_col};
         cmd.last    = emit_last;
         if (emit_last) begin
            load_col_in   = '0;
            load_row_in   = '0;
            emit_row_in   = '0;
            emit_col_in   = '0;
            frame_full_in = 1'b0;
         end else if (emit_col_next >= eff_height) begin
            emit_col_in = '0;
            emit_row_in = CB'(emit_row_next);
         end else begin
            emit_col_in = RB'(emit_col_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_col_ff   <= '0;
         load_row_ff   <= '0;
         emit_row_ff   <= '0;
         emit_col_ff   <= '0;
         frame_full_ff <= 1'b0;
      end else begin
         load_col_ff   <= load_col_in;
         load_row_ff   <= load_row_in;
         emit_row_ff   <= emit_row_in;
         emit_col_ff   <= emit_col_in;
         frame_full_ff <= frame_full_in;
      end
   end

   assign frame_full = frame_full_ff;

endmodule

`default_nettype wire

[design/image_rotate_90.sv]
`default_nettype none

// A readout item shows its pixel on the rsp_ ports in the cycle after it is accepted.
// Throughput: one item per cycle; each item takes one access on the single frame store port.
// Load items and ignored items give no result. The receiver cannot stall the block.
// Reset clears the size registers to 1, the rotation to left and all load and readout
// positions; busy is high only while reset is high. The frame store is not cleared.
module image_rotate_90 (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic                                  req_operation,
   input  wire logic [irot_pkg::CHAN_BITS-1:0]        req_chan_a,
   input  wire logic [irot_pkg::CHAN_BITS-1:0]        req_chan_b,
   input  wire logic [irot_pkg::CHAN_BITS-1:0]        req_chan_c,
   output logic                                       rsp_valid,
   output logic      [irot_pkg::CHAN_BITS-1:0]        rsp_out_a,
   output logic      [irot_pkg::CHAN_BITS-1:0]        rsp_out_b,
   output logic      [irot_pkg::CHAN_BITS-1:0]        rsp_out_c,
   output logic                                       rsp_frame_end,
   input  wire logic                                  csr_write_en,
   input  wire logic [irot_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [irot_pkg::SIZE_BITS-1:0]        csr_data
);

   localparam int CW = irot_pkg::CHAN_BITS;

   logic [irot_pkg::SIZE_BITS-1:0] image_width_ff, image_width_in;
   logic [irot_pkg::SIZE_BITS-1:0] image_height_ff, image_height_in;
   logic                           rotate_right_ff, rotate_right_in;
   logic                           restart;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           frame_end_ff, frame_end_in;

   logic [irot_pkg::EXT_BITS-1:0]  eff_width, eff_height;
   logic                           accept;
   logic                           frame_full;
   irot_pkg::mem_cmd_type          cmd;
   logic [irot_pkg::PIX_BITS-1:0]  read_pixel;

   assign busy   = reset;
   assign accept = start && !busy;

   // A write to any of the three registers restarts loading and readout; stored pixels stay.
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      rotate_right_in = rotate_right_ff;
      restart         = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            irot_pkg::CSR_IMAGE_WIDTH: begin
               image_width_in = csr_data;
               restart        = 1'b1;
            end
            irot_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_in = csr_data;
               restart         = 1'b1;
            end
            irot_pkg::CSR_ROTATE_RIGHT: begin
               rotate_right_in = csr_data[0];
               restart         = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   assign eff_width  = irot_pkg::clamp_size(image_width_ff, irot_pkg::MAX_WIDTH);
   assign eff_height = irot_pkg::clamp_size(image_height_ff, irot_pkg::MAX_HEIGHT);

   irot_addr_gen u_addr_gen (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .operation    (req_operation),
      .restart      (restart),
      .eff_width    (eff_width),
      .eff_height   (eff_height),
      .rotate_right (rotate_right_ff),
      .cmd          (cmd),
      .frame_full   (frame_full)
   );

   irot_ram #(
      .WIDTH (irot_pkg::PIX_BITS),
      .DEPTH (irot_pkg::DEPTH)
   ) u_frame_store (
      .clock      (clock),
      .write_en   (cmd.write_en),
      .read_en    (cmd.read_en),
      .addr       (cmd.addr),
      .write_data ({req_chan_c, req_chan_b, req_chan_a}),
      .read_data  (read_pixel)
   );

   assign rsp_valid_in = cmd.read_en;
   assign frame_end_in = cmd.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= irot_pkg::SIZE_BITS'(1);
         image_height_ff <= irot_pkg::SIZE_BITS'(1);
         rotate_right_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         frame_end_ff    <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         rotate_right_ff <= rotate_right_in;
         rsp_valid_ff    <= rsp_valid_in;
         frame_end_ff    <= frame_end_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_frame_end = frame_end_ff;
   assign rsp_out_a     = read_pixel[CW-1:0];
   assign rsp_out_b     = read_pixel[2*CW-1:CW];
   assign rsp_out_c     = read_pixel[3*CW-1:2*CW];

   a_rsp_follows_readout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept && req_operation == irot_pkg::OP_READ))
      else $error("result without an accepted readout item");

   a_frame_end_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_frame_end |-> (rsp_valid && !frame_full))
      else $error("frame still marked full after its last pixel");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.write_en && cmd.read_en) && !(cmd.write_en && frame_full) &&
      !(cmd.read_en && !frame_full))
      else $error("frame store access does not match the frame state");

endmodule

`default_nettype wire

[tb/irot_checker.sv]
`timescale 1ns / 1ps

module irot_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic                                  busy,
   input  wire logic                                  req_operation,
   input  wire logic [irot_pkg::CHAN_BITS-1:0]        req_chan_a,
   input  wire logic [irot_pkg::CHAN_BITS-1:0]        req_chan_b,
   input  wire logic [irot_pkg::CHAN_BITS-1:0]        req_chan_c,
   input  wire logic                                  rsp_valid,
   input  wire logic [irot_pkg::CHAN_BITS-1:0]        rsp_out_a,
   input  wire logic [irot_pkg::CHAN_BITS-1:0]        rsp_out_b,
   input  wire logic [irot_pkg::CHAN_BITS-1:0]        rsp_out_c,
   input  wire logic                                  rsp_frame_end,
   input  wire logic                                  csr_write_en,
   input  wire logic [irot_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [irot_pkg::SIZE_BITS-1:0]        csr_data,
   output int                                         mismatch_count,
   output int                                         pending_count,
   output int                                         pixel_count,
   output int                                         frame_count
);

   localparam int CB = irot_pkg::CHAN_BITS;
   localparam int SB = irot_pkg::SIZE_BITS;

   typedef struct packed {
      logic [CB-1:0] chan_a;
      logic [CB-1:0] chan_b;
      logic [CB-1:0] chan_c;
      logic          last;
   } rotated_px_type;

   logic [irot_pkg::PIX_BITS-1:0] frame_mem [irot_pkg::DEPTH];
   rotated_px_type                expected_px [$];
   logic [SB-1:0]                 width_reg;
   logic [SB-1:0]                 height_reg;
   logic                          turn_right;
   logic                          frame_full;
   int                            load_row;
   int                            load_col;
   int                            emit_row;
   int                            emit_col;

   function automatic int limit_size(input logic [SB-1:0] value, input int max_size);
      if (value == '0) begin
         return 1;
      end
      if (int'(value) > max_size) begin
         return max_size;
      end
      return int'(value);
   endfunction

   task automatic clear_positions();
      load_row   = 0;
      load_col   = 0;
      emit_row   = 0;
      emit_col   = 0;
      frame_full = 1'b0;
   endtask

   task automatic note_mismatch(input string field, input logic [CB-1:0] want,
                                input logic [CB-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: rotated pixel %0d: %s expected 0x%0h, got 0x%0h",
                  $time, pixel_count, field, want, got);
      end
   endtask

   // Any write to a known register restarts loading and readout; the store keeps its pixels.
   task automatic apply_write(input logic [irot_pkg::CSR_INDEX_BITS-1:0] index,
                              input logic [SB-1:0] data);
      logic known;
      known = 1'b1;
      case (index)
         irot_pkg::CSR_IMAGE_WIDTH: begin
            width_reg = data;
         end
         irot_pkg::CSR_IMAGE_HEIGHT: begin
            height_reg = data;
         end
         irot_pkg::CSR_ROTATE_RIGHT: begin
            turn_right = data[0];
         end
         default: begin
            known = 1'b0;
         end
      endcase
      if (known) begin
         clear_positions();
      end
   endtask

   task automatic rotate_item(input logic op, input logic [CB-1:0] a,
                              input logic [CB-1:0] b, input logic [CB-1:0] c);
      int                            w;
      int                            h;
      int                            src_row;
      int                            src_col;
      logic [irot_pkg::PIX_BITS-1:0] word;
      rotated_px_type                px;
      w = limit_size(width_reg, irot_pkg::MAX_WIDTH);
      h = limit_size(height_reg, irot_pkg::MAX_HEIGHT);
      if (op == irot_pkg::OP_LOAD) begin
         if (!frame_full) begin
            frame_mem[load_row * irot_pkg::MAX_WIDTH + load_col] = {c, b, a};
            load_col++;
            if (load_col >= w) begin
               load_col = 0;
               load_row++;
               if (load_row >= h) begin
                  load_row   = 0;
                  frame_full = 1'b1;
                  emit_row   = 0;
                  emit_col   = 0;
               end
            end
         end
      end else if (frame_full) begin
         // Output row i walks the source columns, output column j the source rows.
         if (turn_right) begin
            src_row = h - 1 - emit_col;
            src_col = emit_row;
         end else begin
            src_row = emit_col;
            src_col = w - 1 - emit_row;
         end
         word      = frame_mem[src_row * irot_pkg::MAX_WIDTH + src_col];
         px.chan_a = word[CB-1:0];
         px.chan_b = word[2*CB-1:CB];
         px.chan_c = word[3*CB-1:2*CB];
         px.last   = (emit_row + 1 >= w) && (emit_col + 1 >= h);
         expected_px.push_back(px);
         emit_col++;
         if (emit_col >= h) begin
            emit_col = 0;
            emit_row++;
         end
         if (px.last) begin
            clear_positions();
         end
      end
   endtask

   always @(posedge clock) begin : watch
      rotated_px_type want;
      if (reset) begin
         width_reg      = SB'(1);
         height_reg     = SB'(1);
         turn_right     = 1'b0;
         mismatch_count = 0;
         pixel_count    = 0;
         frame_count    = 0;
         clear_positions();
         expected_px.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_px.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected pixel a=0x%0h b=0x%0h c=0x%0h frame_end=%b",
                           $time, rsp_out_a, rsp_out_b, rsp_out_c, rsp_frame_end);
               end
            end else begin
               want = expected_px.pop_front();
               if (rsp_out_a !== want.chan_a) begin
                  note_mismatch("out_a", want.chan_a, rsp_out_a);
               end
               if (rsp_out_b !== want.chan_b) begin
                  note_mismatch("out_b", want.chan_b, rsp_out_b);
               end
               if (rsp_out_c !== want.chan_c) begin
                  note_mismatch("out_c", want.chan_c, rsp_out_c);
               end
               if (rsp_frame_end !== want.last) begin
                  note_mismatch("frame_end", CB'(want.last), CB'(rsp_frame_end));
               end
            end
            pixel_count++;
            if (rsp_frame_end === 1'b1) begin
               frame_count++;
            end
         end
         if (csr_write_en) begin
            apply_write(csr_index, csr_data);
         end
         if (start && !busy) begin
            rotate_item(req_operation, req_chan_a, req_chan_b, req_chan_c);
         end
      end
      pending_count = expected_px.size();
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int CB = irot_pkg::CHAN_BITS;
   localparam int SB = irot_pkg::SIZE_BITS;
   localparam int IB = irot_pkg::CSR_INDEX_BITS;

   localparam logic [IB-1:0] CSR_UNUSED = 2'd3;
   localparam int BULK_ITEMS = 550;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   logic          req_operation;
   logic [CB-1:0] req_chan_a;
   logic [CB-1:0] req_chan_b;
   logic [CB-1:0] req_chan_c;
   logic          rsp_valid;
   logic [CB-1:0] rsp_out_a;
   logic [CB-1:0] rsp_out_b;
   logic [CB-1:0] rsp_out_c;
   logic          rsp_frame_end;
   logic          csr_write_en;
   logic [IB-1:0] csr_index;
   logic [SB-1:0] csr_data;

   int mismatch_count;
   int pending_count;
   int pixel_count;
   int frame_count;
   int frame_items;
   int ignored_items;
   bit allow_idle;

   logic [SB-1:0] width_shadow;
   logic [SB-1:0] height_shadow;

   image_rotate_90 u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_chan_a    (req_chan_a),
      .req_chan_b    (req_chan_b),
      .req_chan_c    (req_chan_c),
      .rsp_valid     (rsp_valid),
      .rsp_out_a     (rsp_out_a),
      .rsp_out_b     (rsp_out_b),
      .rsp_out_c     (rsp_out_c),
      .rsp_frame_end (rsp_frame_end),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   irot_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_chan_a     (req_chan_a),
      .req_chan_b     (req_chan_b),
      .req_chan_c     (req_chan_c),
      .rsp_valid      (rsp_valid),
      .rsp_out_a      (rsp_out_a),
      .rsp_out_b      (rsp_out_b),
      .rsp_out_c      (rsp_out_c),
      .rsp_frame_end  (rsp_frame_end),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .pixel_count    (pixel_count),
      .frame_count    (frame_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[image_rotate_90] ERROR");
      $finish;
   end

   function automatic int dim_pixels(input logic [SB-1:0] value, input int max_size);
      if (value == '0) begin
         return 1;
      end
      return (int'(value) > max_size) ? max_size : int'(value);
   endfunction

   function automatic logic [CB-1:0] pick_chan();
      case ($urandom_range(0, 7))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return CB'($urandom);
         end
      endcase
   endfunction

   // Mostly small sizes; zero now and then, which the block treats as one.
   function automatic logic [SB-1:0] pick_dim();
      if ($urandom_range(0, 9) == 0) begin
         return '0;
      end
      return SB'($urandom_range(1, 6));
   endfunction

   task automatic send(input logic op, input logic [CB-1:0] a,
                       input logic [CB-1:0] b, input logic [CB-1:0] c);
      int gap;
      gap = 0;
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
      end
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start         = 1'b1;
      req_operation = op;
      req_chan_a    = a;
      req_chan_b    = b;
      req_chan_c    = c;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_pixel(input logic op);
      send(op, pick_chan(), pick_chan(), pick_chan());
   endtask

   // Readout results come in the cycle after the item, so waiting for the checker queue to empty covers the block.
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [IB-1:0] index, input logic [SB-1:0] data);
      settle();
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = index;
      csr_data     = data;
      @(negedge clock);
      csr_write_en = 1'b0;
      if (index == irot_pkg::CSR_IMAGE_WIDTH) begin
         width_shadow = data;
      end else if (index == irot_pkg::CSR_IMAGE_HEIGHT) begin
         height_shadow = data;
      end
   endtask

   // A stray readout item while the frame is still filling must be ignored.
   task automatic load_frame(input int count, input bit noisy);
      for (int i = 0; i < count; i++) begin
         if (noisy && $urandom_range(0, 11) == 0) begin
            send_pixel(irot_pkg::OP_READ);
            ignored_items++;
         end
         send_pixel(irot_pkg::OP_LOAD);
         frame_items++;
      end
   endtask

   // A stray load item while the frame awaits readout must be ignored.
   task automatic read_frame(input int count, input bit noisy);
      for (int i = 0; i < count; i++) begin
         if (noisy && $urandom_range(0, 11) == 0) begin
            send_pixel(irot_pkg::OP_LOAD);
            ignored_items++;
         end
         send_pixel(irot_pkg::OP_READ);
         frame_items++;
      end
   endtask

   initial begin
      int       phase;
      int       n;
      int       cut;
      int       mode;
      bit       must_write;
      bit [2:0] write_mask;

      reset         = 1'b1;
      start         = 1'b0;
      req_operation = irot_pkg::OP_LOAD;
      req_chan_a    = '0;
      req_chan_b    = '0;
      req_chan_c    = '0;
      csr_write_en  = 1'b0;
      csr_index     = irot_pkg::CSR_IMAGE_WIDTH;
      csr_data      = '0;
      allow_idle    = 1'b0;
      frame_items   = 0;
      ignored_items = 0;
      width_shadow  = SB'(1);
      height_shadow = SB'(1);
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // One-pixel frame straight out of reset: early readout and late load are dropped.
      send_pixel(irot_pkg::OP_READ);
      send(irot_pkg::OP_LOAD, '1, '0, '1);
      send_pixel(irot_pkg::OP_LOAD);
      send_pixel(irot_pkg::OP_READ);
      frame_items   += 2;
      ignored_items += 2;

      // 2x2 turned right, with a restart part way through loading.
      write_reg(irot_pkg::CSR_IMAGE_WIDTH, SB'(2));
      write_reg(irot_pkg::CSR_IMAGE_HEIGHT, SB'(2));
      write_reg(irot_pkg::CSR_ROTATE_RIGHT, SB'(1));
      load_frame(3, 1'b0);
      write_reg(irot_pkg::CSR_IMAGE_WIDTH, SB'(2));
      send(irot_pkg::OP_LOAD, '0, '0, '0);
      send(irot_pkg::OP_LOAD, '1, '1, '1);
      send(irot_pkg::OP_LOAD, '1, '0, '1);
      send(irot_pkg::OP_LOAD, '0, '1, '0);
      frame_items += 4;
      read_frame(2, 1'b0);
      send_pixel(irot_pkg::OP_LOAD);
      ignored_items++;
      read_frame(2, 1'b0);

      // Zero width counts as one; a write to the unused index must not restart loading.
      write_reg(irot_pkg::CSR_IMAGE_WIDTH, '0);
      write_reg(irot_pkg::CSR_IMAGE_HEIGHT, SB'(3));
      write_reg(irot_pkg::CSR_ROTATE_RIGHT, '0);
      load_frame(1, 1'b0);
      write_reg(CSR_UNUSED, '1);
      load_frame(2, 1'b0);
      read_frame(3, 1'b0);

      phase      = 0;
      must_write = 1'b1;
      while (frame_items < BULK_ITEMS) begin
         phase++;
         allow_idle = ($urandom_range(0, 3) != 0) && (frame_items < BULK_ITEMS - 80);
         if (phase == 4) begin
            // One frame at full width or full height, given above the maximum. The
            // rotation is chosen so that the first pixels come from the far edge.
            if ($urandom_range(0, 1) == 0) begin
               write_reg(irot_pkg::CSR_IMAGE_WIDTH, '1);
               write_reg(irot_pkg::CSR_IMAGE_HEIGHT, SB'(1));
               write_reg(irot_pkg::CSR_ROTATE_RIGHT, '0);
            end else begin
               write_reg(irot_pkg::CSR_IMAGE_WIDTH, SB'(1));
               write_reg(irot_pkg::CSR_IMAGE_HEIGHT, SB'(300));
               write_reg(irot_pkg::CSR_ROTATE_RIGHT, SB'(1));
            end
            n = dim_pixels(width_shadow, irot_pkg::MAX_WIDTH) *
                dim_pixels(height_shadow, irot_pkg::MAX_HEIGHT);
            load_frame(n, 1'b1);
            read_frame(32, 1'b1);
            must_write = 1'b1;
         end else begin
            if (must_write || $urandom_range(0, 3) != 0) begin
               write_mask = 3'($urandom_range(1, 7));
               if (must_write) begin
                  write_mask[1:0] = 2'b11;
               end
               if (write_mask[0]) begin
                  write_reg(irot_pkg::CSR_IMAGE_WIDTH, pick_dim());
               end
               if (write_mask[1]) begin
                  write_reg(irot_pkg::CSR_IMAGE_HEIGHT, pick_dim());
               end
               if (write_mask[2]) begin
                  write_reg(irot_pkg::CSR_ROTATE_RIGHT, SB'($urandom_range(0, 1)));
               end
            end
            n    = dim_pixels(width_shadow, irot_pkg::MAX_WIDTH) *
                   dim_pixels(height_shadow, irot_pkg::MAX_HEIGHT);
            mode = $urandom_range(0, 7);
            if (n > 1 && mode == 0) begin
               // Abandon the load; the next register write restarts the block.
               cut = $urandom_range(1, n - 1);
               load_frame(cut, 1'b1);
               must_write = 1'b1;
            end else if (n > 1 && mode == 1) begin
               cut = $urandom_range(1, n - 1);
               load_frame(n, 1'b1);
               read_frame(cut, 1'b1);
               must_write = 1'b1;
            end else begin
               load_frame(n, 1'b1);
               read_frame(n, 1'b1);
               must_write = 1'b0;
            end
         end
      end

      settle();
      $display("Checked %0d rotated pixels and %0d complete frames over %0d phases.",
               pixel_count, frame_count, phase);
      $display("Sent %0d load and readout items and %0d items the block had to ignore.",
               frame_items, ignored_items);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("[image_rotate_90] OK");
      end else begin
         $display("[image_rotate_90] ERROR");
      end
      $finish;
   end

endmodule
